/* rtl/ctk_pkg.sv */
// ----------------------------------------------------------------------------
// ctk_pkg
// Types and constants shared by the character stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctk_pkg;

	localparam int TEXT_BYTES_DEF = 8;
	localparam int WORD_BYTES     = 8;
	localparam int RES_DEPTH      = 4;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		KIND_IDENT    = 4'd0,
		KIND_NUMBER   = 4'd1,
		KIND_LPAREN   = 4'd2,
		KIND_RPAREN   = 4'd3,
		KIND_COMMA    = 4'd4,
		KIND_ASSIGN   = 4'd5,
		KIND_PLUS     = 4'd6,
		KIND_MINUS    = 4'd7,
		KIND_STAR     = 4'd8,
		KIND_SLASH    = 4'd9,
		KIND_LBRACE   = 4'd10,
		KIND_RBRACE   = 4'd11,
		KIND_SEMI     = 4'd12,
		KIND_FUNCTION = 4'd13,
		KIND_RETURN   = 4'd14
	} kind_t;

	// Keywords packed with the first character in the low byte.
	localparam logic [63:0] KW_FUNCTION = 64'h6E6F6974636E7566;
	localparam logic [63:0] KW_RETURN   = 64'h00006E7275746572;
	localparam logic [7:0]  LEN_FUNCTION = 8'd8;
	localparam logic [7:0]  LEN_RETURN   = 8'd6;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] text;
		logic [7:0]  length;
		logic        truncated;
		logic        last;
	} token_t;

endpackage

`default_nettype wire

/* rtl/ctk_if.sv */
// ----------------------------------------------------------------------------
// ctk_if
// Valid/ready channels for characters in and tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctk_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ctk_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [63:0] token_text;
	logic [7:0]  text_length;
	logic        text_truncated;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_text,
		output text_length, output text_truncated, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_text,
		input text_length, input text_truncated, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/char_stream_tokenizer.sv */
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Splits a byte stream into identifier, number, keyword and punctuation
// tokens.
// ----------------------------------------------------------------------------
//  Channel     Direction  Items            Per item
//  char_in     sink       one character    char_code, end_of_text
//  token_out   source     one token        kind, text, length, truncated, last
//
//  A character is accepted in every cycle while the token queue has room.
//  It waits in the input register until the queue has room; then its tokens,
//  at most two, are written into the four entry queue before they can leave.
//  A character that gives two tokens drains them one at a time.
//  Reset clears the pending word, the input register and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_tokenizer
	import ctk_pkg::*;
#(
	parameter int TEXT_BYTES = TEXT_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ctk_char_if.sink    char_in,
	ctk_token_if.source token_out
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;
	logic       advance, room, take;
	token_t     res_a, res_b, out_token;
	logic [1:0] res_cnt;

	assign advance       = valid_s1 && room;
	assign char_in.ready = !valid_s1 || advance;
	assign take          = char_in.valid && char_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_in.char_code;
			eot_s1  <= char_in.end_of_text;
		end
	end

	ctk_lexer #(
		.TEXT_BYTES(TEXT_BYTES)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.char_code   (char_s1),
		.end_of_text (eot_s1),
		.res_a       (res_a),
		.res_b       (res_b),
		.res_cnt     (res_cnt)
	);

	ctk_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (advance ? res_cnt : 2'd0),
		.push_a    (res_a),
		.push_b    (res_b),
		.room      (room),
		.out_valid (token_out.valid),
		.out_ready (token_out.ready),
		.out_token (out_token)
	);

	assign token_out.token_kind     = 4'(out_token.kind);
	assign token_out.token_text     = out_token.text;
	assign token_out.text_length    = out_token.length;
	assign token_out.text_truncated = out_token.truncated;
	assign token_out.last_of_run    = out_token.last;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(char_s1) && $stable(eot_s1))
		else $error("Input register changed while the queue was full.");

endmodule

`default_nettype wire

/* rtl/ctk_lexer.sv */
// ----------------------------------------------------------------------------
// ctk_lexer
// Pending word state, character classes and the up to two tokens of a step.
// ----------------------------------------------------------------------------
`default_nettype none

module ctk_lexer
	import ctk_pkg::*;
#(
	parameter int TEXT_BYTES = TEXT_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_code,
	input  wire logic       end_of_text,
	output token_t          res_a,
	output token_t          res_b,
	output logic [1:0]      res_cnt
);

	localparam logic [7:0] TRUNC_LIMIT   = 8'(TEXT_BYTES);
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	mode_t       mode_q;
	logic [63:0] bytes_q;
	logic [7:0]  count_q;

	logic        is_letter, is_digit, ident_ch, taken, flush_old;
	logic        punct_hit, flush_last;
	kind_t       punct_kind;
	mode_t       mid_mode;
	logic [63:0] mid_bytes;
	logic [7:0]  mid_count;
	token_t      old_res, punct_res, last_res, first_res, second_res;

	function automatic token_t word_token(mode_t m, logic [63:0] b, logic [7:0] n);
		token_t t;
		t.kind = (m == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
		if (m != MODE_NUMBER) begin
			if (n == LEN_FUNCTION && b == KW_FUNCTION)
				t.kind = KIND_FUNCTION;
			else if (n == LEN_RETURN && b == KW_RETURN)
				t.kind = KIND_RETURN;
		end
		t.text      = b;
		t.length    = n;
		t.truncated = (n > TRUNC_LIMIT);
		t.last      = 1'b0;
		return t;
	endfunction

	always_comb begin
		is_letter = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
		is_digit  = (char_code inside {[8'h30:8'h39]});
		ident_ch  = is_letter || is_digit || (char_code == CH_UNDERSCORE);
		punct_hit = 1'b1;
		case (char_code)
			8'h28:   punct_kind = KIND_LPAREN;
			8'h29:   punct_kind = KIND_RPAREN;
			8'h2C:   punct_kind = KIND_COMMA;
			8'h3D:   punct_kind = KIND_ASSIGN;
			8'h2B:   punct_kind = KIND_PLUS;
			8'h2D:   punct_kind = KIND_MINUS;
			8'h2A:   punct_kind = KIND_STAR;
			8'h2F:   punct_kind = KIND_SLASH;
			8'h7B:   punct_kind = KIND_LBRACE;
			8'h7D:   punct_kind = KIND_RBRACE;
			8'h3B:   punct_kind = KIND_SEMI;
			default: begin
				punct_kind = KIND_IDENT;
				punct_hit  = 1'b0;
			end
		endcase
	end

	always_comb begin
		taken     = (mode_q == MODE_IDENT && ident_ch) || (mode_q == MODE_NUMBER && is_digit);
		flush_old = (mode_q != MODE_IDLE) && !taken;
		old_res   = word_token(mode_q, bytes_q, count_q);

		if (taken) begin
			mid_mode  = mode_q;
			mid_bytes = bytes_q;
			if (count_q < 8'(WORD_BYTES))
				mid_bytes = bytes_q | ({56'd0, char_code} << {count_q[2:0], 3'b000});
			mid_count = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
		end else if (is_letter || is_digit) begin
			mid_mode  = is_letter ? MODE_IDENT : MODE_NUMBER;
			mid_bytes = {56'd0, char_code};
			mid_count = 8'd1;
		end else begin
			mid_mode  = MODE_IDLE;
			mid_bytes = 64'd0;
			mid_count = 8'd0;
		end

		punct_res           = '0;
		punct_res.kind      = punct_kind;
		flush_last          = end_of_text && (mid_mode != MODE_IDLE);
		last_res            = word_token(mid_mode, mid_bytes, mid_count);

		first_res  = flush_old ? old_res : (!taken && punct_hit) ? punct_res : last_res;
		second_res = (!taken && punct_hit) ? punct_res : last_res;
		res_cnt    = 2'(flush_old) + 2'(!taken && punct_hit) + 2'(flush_last);

		res_a      = first_res;
		res_a.last = (res_cnt == 2'd1);
		res_b      = second_res;
		res_b.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			bytes_q <= 64'd0;
			count_q <= 8'd0;
		end else if (step) begin
			if (flush_last) begin
				mode_q  <= MODE_IDLE;
				bytes_q <= 64'd0;
				count_q <= 8'd0;
			end else begin
				mode_q  <= mid_mode;
				bytes_q <= mid_bytes;
				count_q <= mid_count;
			end
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) == (count_q == 8'd0))
		else $error("Pending word length disagrees with the word mode.");

	a_eot_flush: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_text |=> mode_q == MODE_IDLE)
		else $error("A word is still pending after the final character.");

endmodule

`default_nettype wire

/* rtl/ctk_res_fifo.sv */
// ----------------------------------------------------------------------------
// ctk_res_fifo
// Small token queue that takes up to two tokens per cycle and gives one when out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ctk_res_fifo
	import ctk_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   [1:0] push_cnt,
	input  wire token_t push_a,
	input  wire token_t push_b,
	output logic        room,
	output logic        out_valid,
	input  wire logic   out_ready,
	output token_t      out_token
);

	localparam int AW = $clog2(RES_DEPTH);
	localparam int CW = AW + 1;

	token_t          mem_q [RES_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_token = mem_q[rd_ptr_q];
	assign room      = (count_q <= CW'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push_a;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_q + AW'(1)] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			count_q  <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RES_DEPTH))
		else $error("Token queue holds more than its depth.");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd0 |-> room)
		else $error("Tokens pushed without room for two.");

endmodule

`default_nettype wire
